@@ rtl/cie_pkg.sv @@
// Shared constants, register codes and saturation and sign-extension helpers for the CIR Euler step unit.
package cie_pkg;

   localparam int DATA_W = 32;
   localparam int INTEG_W = 40;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_C_COEF         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_D_COEF         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_REVERSION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_LEVEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LEVEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FX_CORRELATION = 3'd5;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // sign-extend a 32-bit value to 64 bits
   function automatic logic signed [63:0] sext64(input logic signed [DATA_W-1:0] v);
      return {{(64-DATA_W){v[DATA_W-1]}}, v};
   endfunction

endpackage

@@ rtl/cir_intensity_euler_step_unit.sv @@
// Top level of the CIR intensity Euler step unit: sequencer, state and channels.
//
// Usage:
//  - req_* carries one step per beat: path_start, normal draw, root of dt, theta, FX vol.
//    A beat is taken when req_valid is high and req_stall is low. req_stall is high
//    while a step is in progress; the unit works on one step at a time.
//  - rsp_* returns one beat per step: new intensity, running integral, floored flag.
//    The result sits in an output register; hold it while rsp_stall is high. The next
//    request is taken while a result still waits; that step then holds in S_SUM
//    until the output register frees.
//  - csr_* writes the six Q format coefficients; csr_ready is always high. Write
//    only while no step is in flight. Indexes past the list are dropped.
//  - Sequence: ten passes through the one shared multiplier (issue state plus
//    capture state) and a square root of the variance. The square root
//    recurrence (two radicand bits per cycle) starts after the c*x pass and
//    overlaps the next four passes; the last four passes wait for the root.
//  - A new step is taken only once the current one has left S_SUM.
//  - Reset clears the coefficients, the intensity and the integral to zero and
//    leaves both channels idle.
module cir_intensity_euler_step_unit #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_path_start,
   input  logic signed [cie_pkg::DATA_W-1:0]    req_normal_sample,
   input  logic [cie_pkg::DATA_W-2:0]           req_root_dt,
   input  logic signed [cie_pkg::DATA_W-1:0]    req_mean_level,
   input  logic signed [cie_pkg::DATA_W-1:0]    req_fx_vol,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cie_pkg::DATA_W-1:0]    rsp_new_intensity,
   output logic signed [cie_pkg::INTEG_W-1:0]   rsp_integrated_intensity,
   output logic                                 rsp_was_floored,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cie_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic signed [cie_pkg::DATA_W-1:0]    csr_data
);

   localparam int ITER = (32 + FRAC_BITS) / 2;
   localparam int OPW  = 2 * ITER;
   localparam int DW   = cie_pkg::DATA_W;
   localparam int IW   = cie_pkg::INTEG_W;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DT_I,  S_DT_W,
      S_CX_I,  S_CX_W,
      S_INC_I, S_INC_W,
      S_BX_I,  S_BX_W,
      S_DR_I,  S_DR_W,
      S_RF_I,  S_RF_W,
      S_SQ,
      S_VR_I,  S_VR_W,
      S_DF_I,  S_DF_W,
      S_FV_I,  S_FV_W,
      S_FC_I,  S_FC_W,
      S_SUM
   } state_type;

   state_type state_ff, state_in;

   // coefficients
   logic signed [DW-1:0] c_coef_ff, c_coef_in;
   logic signed [DW-1:0] d_coef_ff, d_coef_in;
   logic signed [DW-1:0] beta_ff,   beta_in;
   logic signed [DW-1:0] floor_ff,  floor_in;
   logic signed [DW-1:0] start_ff,  start_in;
   logic signed [DW-1:0] rho_ff,    rho_in;

   // path state
   logic signed [DW-1:0] x_ff,     x_in;
   logic signed [IW-1:0] integ_ff, integ_in;

   // captured request beat
   logic signed [DW-1:0] w_ff,     w_in;
   logic [DW-2:0]        rdt_ff,   rdt_in;
   logic signed [DW-1:0] theta_ff, theta_in;
   logic signed [DW-1:0] fxv_ff,   fxv_in;

   // intermediates
   logic signed [DW-1:0] dt_ff,    dt_in;
   logic signed [DW-1:0] tmp_ff,   tmp_in;
   logic signed [DW-1:0] drift_ff, drift_in;
   logic signed [DW-1:0] diff_ff,  diff_in;
   logic signed [DW-1:0] rf_ff,    rf_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_x_ff,     rsp_x_in;
   logic signed [IW-1:0] rsp_integ_ff, rsp_integ_in;
   logic                 rsp_floor_ff, rsp_floor_in;

   // shared units
   logic signed [DW-1:0] mul_a, mul_b, mul_sat;
   logic signed [63:0]   mul_wide;
   logic                 sq_start, sq_valid;
   logic [OPW-1:0]       sq_rad;
   logic [DW-1:0]        sq_root;
   logic signed [DW-1:0] vol;

   // datapath helpers
   logic signed [DW-1:0] var_sat;
   logic [DW-2:0]        var_pos;
   logic signed [64:0]   integ_sum;
   logic signed [63:0]   step_sum;
   logic signed [DW-1:0] x_next;
   logic                 out_free;

   cie_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock     (clock),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .prod_sat  (mul_sat),
      .prod_wide (mul_wide)
   );

   cie_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .start      (sq_start),
      .radicand   (sq_rad),
      .root_valid (sq_valid),
      .root       (sq_root)
   );

   assign vol = $signed(sq_root);

   // variance: sat32(c*x + d), negative clamped to zero
   assign var_sat  = cie_pkg::sat32(cie_pkg::sext64(mul_sat) + cie_pkg::sext64(d_coef_ff));
   assign var_pos  = var_sat[DW-1] ? '0 : var_sat[DW-2:0];
   assign sq_rad   = {{(OPW-DW+1){1'b0}}, var_pos} << FRAC_BITS;
   assign sq_start = (state_ff == S_CX_W);

   assign integ_sum = {{(65-IW){integ_ff[IW-1]}}, integ_ff} + {mul_wide[63], mul_wide};

   assign step_sum = cie_pkg::sext64(x_ff) + cie_pkg::sext64(drift_ff)
                   + cie_pkg::sext64(diff_ff) - cie_pkg::sext64(tmp_ff);
   assign x_next   = cie_pkg::sat32(step_sum);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // multiplier operand select per issue state
   always_comb begin
      case (state_ff)
         S_DT_I:  begin mul_a = $signed({1'b0, rdt_ff}); mul_b = $signed({1'b0, rdt_ff}); end
         S_CX_I:  begin mul_a = c_coef_ff; mul_b = x_ff;  end
         S_INC_I: begin mul_a = x_ff;      mul_b = dt_ff; end
         S_BX_I:  begin mul_a = beta_ff;   mul_b = x_ff;  end
         S_DR_I:  begin mul_a = tmp_ff;    mul_b = dt_ff; end
         S_RF_I:  begin mul_a = rho_ff;    mul_b = fxv_ff; end
         S_VR_I:  begin mul_a = vol;       mul_b = $signed({1'b0, rdt_ff}); end
         S_DF_I:  begin mul_a = tmp_ff;    mul_b = w_ff;  end
         S_FV_I:  begin mul_a = rf_ff;     mul_b = vol;   end
         S_FC_I:  begin mul_a = tmp_ff;    mul_b = dt_ff; end
         default: begin mul_a = '0;        mul_b = '0;    end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      c_coef_in    = c_coef_ff;
      d_coef_in    = d_coef_ff;
      beta_in      = beta_ff;
      floor_in     = floor_ff;
      start_in     = start_ff;
      rho_in       = rho_ff;
      x_in         = x_ff;
      integ_in     = integ_ff;
      w_in         = w_ff;
      rdt_in       = rdt_ff;
      theta_in     = theta_ff;
      fxv_in       = fxv_ff;
      dt_in        = dt_ff;
      tmp_in       = tmp_ff;
      drift_in     = drift_ff;
      diff_in      = diff_ff;
      rf_in        = rf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_integ_in = rsp_integ_ff;
      rsp_floor_in = rsp_floor_ff;

      // coefficient writes; indexes past the list fall through
      if (csr_valid) begin
         case (csr_index)
            cie_pkg::CSR_C_COEF:         c_coef_in = csr_data;
            cie_pkg::CSR_D_COEF:         d_coef_in = csr_data;
            cie_pkg::CSR_MEAN_REVERSION: beta_in   = csr_data;
            cie_pkg::CSR_FLOOR_LEVEL:    floor_in  = csr_data;
            cie_pkg::CSR_START_LEVEL:    start_in  = csr_data;
            cie_pkg::CSR_FX_CORRELATION: rho_in    = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               w_in     = req_normal_sample;
               rdt_in   = req_root_dt;
               theta_in = req_mean_level;
               fxv_in   = req_fx_vol;
               // reload the path before this step
               if (req_path_start) begin
                  x_in     = start_ff;
                  integ_in = '0;
               end
               state_in = S_DT_I;
            end
         end
         S_DT_I:  state_in = S_DT_W;
         S_DT_W: begin
            dt_in    = mul_sat;
            state_in = S_CX_I;
         end
         S_CX_I:  state_in = S_CX_W;
         S_CX_W:  state_in = S_INC_I;   // root starts here
         S_INC_I: state_in = S_INC_W;
         S_INC_W: begin
            // integral uses the intensity held before the step
            if (integ_sum > 65'sd549755813887) begin
               integ_in = 40'sh7F_FFFF_FFFF;
            end else if (integ_sum < -65'sd549755813888) begin
               integ_in = 40'sh80_0000_0000;
            end else begin
               integ_in = integ_sum[IW-1:0];
            end
            state_in = S_BX_I;
         end
         S_BX_I:  state_in = S_BX_W;
         S_BX_W: begin
            tmp_in   = cie_pkg::sat32(cie_pkg::sext64(theta_ff) - cie_pkg::sext64(mul_sat));
            state_in = S_DR_I;
         end
         S_DR_I:  state_in = S_DR_W;
         S_DR_W: begin
            drift_in = mul_sat;
            state_in = S_RF_I;
         end
         S_RF_I:  state_in = S_RF_W;
         S_RF_W: begin
            rf_in    = mul_sat;
            state_in = S_SQ;
         end
         S_SQ: begin
            if (sq_valid) begin
               state_in = S_VR_I;
            end
         end
         S_VR_I:  state_in = S_VR_W;
         S_VR_W: begin
            tmp_in   = mul_sat;
            state_in = S_DF_I;
         end
         S_DF_I:  state_in = S_DF_W;
         S_DF_W: begin
            diff_in  = mul_sat;
            state_in = S_FV_I;
         end
         S_FV_I:  state_in = S_FV_W;
         S_FV_W: begin
            tmp_in   = mul_sat;
            state_in = S_FC_I;
         end
         S_FC_I:  state_in = S_FC_W;
         S_FC_W: begin
            tmp_in   = mul_sat;     // FX correction term
            state_in = S_SUM;
         end
         S_SUM: begin
            // hold until the output register frees
            if (out_free) begin
               if ((c_coef_ff != '0) && (x_next < floor_ff)) begin
                  x_in         = floor_ff;
                  rsp_x_in     = floor_ff;
                  rsp_floor_in = 1'b1;
               end else begin
                  x_in         = x_next;
                  rsp_x_in     = x_next;
                  rsp_floor_in = 1'b0;
               end
               rsp_integ_in = integ_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         c_coef_ff    <= '0;
         d_coef_ff    <= '0;
         beta_ff      <= '0;
         floor_ff     <= '0;
         start_ff     <= '0;
         rho_ff       <= '0;
         x_ff         <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c_coef_ff    <= c_coef_in;
         d_coef_ff    <= d_coef_in;
         beta_ff      <= beta_in;
         floor_ff     <= floor_in;
         start_ff     <= start_in;
         rho_ff       <= rho_in;
         x_ff         <= x_in;
         integ_ff     <= integ_in;
      end
      w_ff         <= w_in;
      rdt_ff       <= rdt_in;
      theta_ff     <= theta_in;
      fxv_ff       <= fxv_in;
      dt_ff        <= dt_in;
      tmp_ff       <= tmp_in;
      drift_ff     <= drift_in;
      diff_ff      <= diff_in;
      rf_ff        <= rf_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_integ_ff <= rsp_integ_in;
      rsp_floor_ff <= rsp_floor_in;
   end

   assign req_stall                = (state_ff != S_IDLE);
   assign csr_ready                = 1'b1;
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_new_intensity        = rsp_x_ff;
   assign rsp_integrated_intensity = rsp_integ_ff;
   assign rsp_was_floored          = rsp_floor_ff;

endmodule

@@ rtl/cie_mul.sv @@
// Shared 32x32 signed multiplier with registered product and fixed-point rescale.
module cie_mul #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                clock,
   input  logic signed [cie_pkg::DATA_W-1:0]   op_a,
   input  logic signed [cie_pkg::DATA_W-1:0]   op_b,
   output logic signed [cie_pkg::DATA_W-1:0]   prod_sat,
   output logic signed [63:0]                  prod_wide
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = cie_pkg::sext64(op_a) * cie_pkg::sext64(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift rounds toward minus infinity
   assign prod_wide = prod_ff >>> FRAC_BITS;
   assign prod_sat  = cie_pkg::sat32(prod_wide);

endmodule

@@ rtl/cie_sqrt.sv @@
// Digit-recurrence integer square root, two radicand bits per cycle.
module cie_sqrt #(
   parameter int FRAC_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [2*((32+FRAC_BITS)/2)-1:0]   radicand,
   output logic                              root_valid,
   output logic [cie_pkg::DATA_W-1:0]        root
);

   localparam int ITER = (32 + FRAC_BITS) / 2;
   localparam int OPW  = 2 * ITER;
   localparam int RW   = ITER + 2;
   localparam int CW   = $clog2(ITER + 1);

   logic [OPW-1:0]  opnd_ff,  opnd_in;
   logic [RW-1:0]   rem_ff,   rem_in;
   logic [ITER-1:0] root_ff,  root_in;
   logic [CW-1:0]   cnt_ff,   cnt_in;
   logic            busy_ff,  busy_in;
   logic            valid_ff, valid_in;

   logic [RW+1:0] rem_shift;
   logic [RW+1:0] trial;
   logic [RW+1:0] rem_diff;

   assign rem_shift = {rem_ff, opnd_ff[OPW-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign rem_diff  = rem_shift - trial;

   always_comb begin
      opnd_in  = opnd_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      if (start) begin
         opnd_in  = radicand;
         rem_in   = '0;
         root_in  = '0;
         cnt_in   = CW'(ITER);
         busy_in  = 1'b1;
         valid_in = 1'b0;
      end else if (busy_ff) begin
         opnd_in = {opnd_ff[OPW-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_diff[RW-1:0];
            root_in = {root_ff[ITER-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[RW-1:0];
            root_in = {root_ff[ITER-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_valid = valid_ff;
   assign root       = {{(cie_pkg::DATA_W-ITER){1'b0}}, root_ff};

endmodule
